[hw/rtl/hpte_pkg.sv]
`timescale 1ns / 1ps

package hpte_pkg;

  localparam int PTEG_INDEX_BITS = 11;
  localparam int GROUP_SLOTS     = 8;
  localparam int SLOT_W          = 3;
  localparam int TABLE_ROWS      = 1 << PTEG_INDEX_BITS;
  localparam int SLOT_IDX_W      = 14;
  localparam int HASH_W          = 19;
  localparam int MASK_W          = 9;

  localparam logic [31:0] HASH_LOW_MASK  = 32'h0000_03ff;
  localparam logic [31:0] HASH_HIGH_MASK = 32'h0007_fc00;

  // Bit positions inside a 64-bit entry
  localparam int V_POS = 63;
  localparam int R_POS = 8;
  localparam int C_POS = 7;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_INVAL  = 2'd2;

  typedef logic [PTEG_INDEX_BITS-1:0]        group_idx_t;
  typedef logic [GROUP_SLOTS-1:0][63:0]      pte_group_t;

  typedef struct packed {
    logic              match_hit;
    logic [SLOT_W-1:0] match_slot;
    logic [31:0]       match_lo;
    logic              inv_hit;
    logic [SLOT_W-1:0] inv_slot;
    logic              unch_hit;
    logic [SLOT_W-1:0] unch_slot;
    logic              unch_v;
  } grp_scan_t;

  function automatic group_idx_t group_of(logic [HASH_W-1:0] hash, logic [MASK_W-1:0] mask);
    logic [HASH_W-1:0] lo;
    logic [HASH_W-1:0] hi;
    logic [HASH_W-1:0] g;
    lo = hash & HASH_LOW_MASK[HASH_W-1:0];
    hi = ((hash & HASH_HIGH_MASK[HASH_W-1:0]) >> 10) & {{(HASH_W-MASK_W){1'b0}}, mask};
    g  = lo | (hi << 10);
    return g[PTEG_INDEX_BITS-1:0];
  endfunction

  function automatic logic [31:0] make_tag(logic [23:0] vsid, logic [5:0] api, logic sec);
    return {1'b1, vsid, sec, api};
  endfunction

  function automatic logic [SLOT_IDX_W-1:0] slot_idx(group_idx_t g, logic [SLOT_W-1:0] s);
    logic [SLOT_IDX_W+PTEG_INDEX_BITS+SLOT_W-1:0] full;
    full = {{SLOT_IDX_W{1'b0}}, g, s};
    return full[SLOT_IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/hashed_page_table_engine_top.sv]
`timescale 1ns / 1ps
// After the input transfer the engine steps through RD_S, EVAL and FIN, and registers the result
//   onto the output once FIN can load it. Input is taken only in IDLE, so operations do not
//   overlap; the primary and secondary group reads share the table's single read port and one group comparator.
// Reset: hash_mask clears to 0, then a clearing pass zeroes the table one group per cycle
//   while no input is accepted; configuration writes are taken throughout.

module hashed_page_table_engine_top
  import hpte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MASK_W-1:0] cfg_wdata_i,    // hash_mask
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [87:0]       s_axis_tdata,   // virt_addr[31:0], segment_vsid[55:32],
                                            // entry_word[87:56]
  input  logic [1:0]        s_axis_tuser,   // mode[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata    // found[0], entry_out[32:1], slot_index[46:33],
                                            // used_secondary[47], displaced_valid[48], zero
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD_S  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  typedef struct packed {
    logic                  found;
    logic [31:0]           entry;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  sec;
    logic                  disp;
  } hpte_res_t;

  logic [2:0]        state_q, state_d;
  group_idx_t        clr_cnt_q;
  logic [MASK_W-1:0] hash_mask_q;
  logic              out_valid_q;
  logic [55:0]       out_data_q;

  logic [1:0]  mode_q;
  logic [23:0] vsid_q;
  logic [5:0]  api_q;
  logic [31:0] word_q;
  group_idx_t  pg_q, sg_q;
  grp_scan_t   pscan_q;
  hpte_res_t   res_q, res_d;

  pte_group_t  pte_mem [TABLE_ROWS];
  pte_group_t  rd_data_q;
  group_idx_t  rd_row;

  logic                   wr_en;
  group_idx_t             wr_row;
  logic [GROUP_SLOTS-1:0] wr_mask;
  logic [63:0]            wr_entry;

  logic [HASH_W-1:0] in_hash;
  group_idx_t        in_pg, in_sg;
  logic              in_xfer, out_load;

  grp_scan_t   scan;
  logic [31:0] cmp_tag;

  assign in_hash = s_axis_tdata[32+HASH_W-1:32] ^ {3'd0, s_axis_tdata[27:12]};
  assign in_pg   = group_of(in_hash, hash_mask_q);
  assign in_sg   = group_of(~in_hash, hash_mask_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Shared group comparator: primary group in RD_S, secondary group in EVAL
  assign cmp_tag = make_tag(vsid_q, api_q, state_q == ST_EVAL);

  hpte_group_cmp u_cmp (
    .grp_i  (rd_data_q),
    .tag_i  (cmp_tag),
    .scan_o (scan)
  );

  assign rd_row = (state_q == ST_IDLE) ? in_pg : sg_q;

  always_comb begin
    res_d    = '0;
    wr_en    = 1'b0;
    wr_row   = clr_cnt_q;
    wr_mask  = '1;
    wr_entry = '0;
    if (state_q == ST_EVAL) begin
      wr_mask = '0;
      if (mode_q == MODE_LOOKUP || mode_q == MODE_INVAL) begin
        if (pscan_q.match_hit) begin
          res_d.found = 1'b1;
          res_d.slot  = slot_idx(pg_q, pscan_q.match_slot);
          res_d.entry = (mode_q == MODE_LOOKUP) ? pscan_q.match_lo : '0;
          res_d.disp  = (mode_q == MODE_INVAL);
          wr_row      = pg_q;
          wr_mask[pscan_q.match_slot] = 1'b1;
        end else if (scan.match_hit) begin
          res_d.found = 1'b1;
          res_d.sec   = 1'b1;
          res_d.slot  = slot_idx(sg_q, scan.match_slot);
          res_d.entry = (mode_q == MODE_LOOKUP) ? scan.match_lo : '0;
          res_d.disp  = (mode_q == MODE_INVAL);
          wr_row      = sg_q;
          wr_mask[scan.match_slot] = 1'b1;
        end
        wr_en = (mode_q == MODE_INVAL) && res_d.found;
      end else if (mode_q == MODE_INSERT) begin
        res_d.found = 1'b1;
        priority if (pscan_q.inv_hit) begin
          wr_row = pg_q;
          wr_mask[pscan_q.inv_slot] = 1'b1;
          res_d.slot = slot_idx(pg_q, pscan_q.inv_slot);
        end else if (scan.inv_hit) begin
          res_d.sec  = 1'b1;
          wr_row     = sg_q;
          wr_mask[scan.inv_slot] = 1'b1;
          res_d.slot = slot_idx(sg_q, scan.inv_slot);
        end else if (pscan_q.unch_hit) begin
          res_d.disp = pscan_q.unch_v;
          wr_row     = pg_q;
          wr_mask[pscan_q.unch_slot] = 1'b1;
          res_d.slot = slot_idx(pg_q, pscan_q.unch_slot);
        end else if (scan.unch_hit) begin
          res_d.sec  = 1'b1;
          res_d.disp = scan.unch_v;
          wr_row     = sg_q;
          wr_mask[scan.unch_slot] = 1'b1;
          res_d.slot = slot_idx(sg_q, scan.unch_slot);
        end else begin
          res_d.sec  = 1'b1;
          res_d.disp = rd_data_q[0][V_POS];
          wr_row     = sg_q;
          wr_mask[0] = 1'b1;
          res_d.slot = slot_idx(sg_q, '0);
        end
        wr_en    = 1'b1;
        wr_entry = {make_tag(vsid_q, api_q, res_d.sec), word_q};
      end
    end else if (state_q == ST_CLEAR) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == group_idx_t'(TABLE_ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_d = ST_RD_S;
      ST_RD_S:  state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      hash_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) hash_mask_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table: one group read and one masked group write per cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= pte_mem[rd_row];
    if (wr_en) begin
      for (int i = 0; i < GROUP_SLOTS; i++) begin
        if (wr_mask[i]) pte_mem[wr_row][i] <= wr_entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= s_axis_tuser;
      vsid_q <= s_axis_tdata[55:32];
      api_q  <= s_axis_tdata[27:22];
      word_q <= s_axis_tdata[87:56];
      pg_q   <= in_pg;
      sg_q   <= in_sg;
    end
    if (state_q == ST_RD_S) pscan_q <= scan;
    if (state_q == ST_EVAL) res_q <= res_d;
    if (out_load) begin
      out_data_q <= {7'd0, res_q.disp, res_q.sec, res_q.slot, res_q.entry, res_q.found};
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("input accepted during table clear");

  a_write_only_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q != ST_CLEAR) |-> (mode_q == MODE_INSERT || mode_q == MODE_INVAL))
    else $error("table written by a lookup");

  a_insert_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && mode_q == MODE_INSERT) |-> res_q.found)
    else $error("insert result without found");

  a_lookup_no_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && mode_q == MODE_LOOKUP) |-> !res_q.disp)
    else $error("lookup flagged a displaced entry");

  a_accept_reads_secondary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RD_S && rd_row == sg_q))
    else $error("secondary group read not issued after transfer");

endmodule

[hw/rtl/hpte_group_cmp.sv]
`timescale 1ns / 1ps

module hpte_group_cmp
  import hpte_pkg::*;
(
  input  pte_group_t  grp_i,
  input  logic [31:0] tag_i,
  output grp_scan_t   scan_o
);

  // Walk from the top slot down so the lowest matching slot wins
  always_comb begin
    scan_o = '0;
    for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
      if (grp_i[i][63:32] == tag_i) begin
        scan_o.match_hit  = 1'b1;
        scan_o.match_slot = SLOT_W'(i);
        scan_o.match_lo   = grp_i[i][31:0];
      end
      if (!grp_i[i][V_POS]) begin
        scan_o.inv_hit  = 1'b1;
        scan_o.inv_slot = SLOT_W'(i);
      end
      if (!grp_i[i][R_POS] && !grp_i[i][C_POS]) begin
        scan_o.unch_hit  = 1'b1;
        scan_o.unch_slot = SLOT_W'(i);
        scan_o.unch_v    = grp_i[i][V_POS];
      end
    end
  end

endmodule

[tb/hpte_checker.sv]
`timescale 1ns / 1ps

module hpte_checker
  import hpte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MASK_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [87:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [55:0]       m_axis_tdata,
  output int                fail_count_o,
  output int                pending_o,
  output int                results_o,
  output int                hits_o,
  output int                secondary_o,
  output int                displaced_o
);

  localparam int TABLE_DEPTH = TABLE_ROWS * GROUP_SLOTS;

  typedef struct packed {
    logic                  found;
    logic [31:0]           entry;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  sec;
    logic                  disp;
  } pte_outcome_t;

  logic [63:0]       pte_shadow [TABLE_DEPTH];
  logic [MASK_W-1:0] mask_q;
  pte_outcome_t      pte_outcomes_q [$];
  pte_outcome_t      want;
  pte_outcome_t      got;
  int                row;

  function automatic logic [SLOT_IDX_W-1:0] group_base(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] g;
    g = {h[HASH_W-1:10] & mask_q, h[9:0]};
    return SLOT_IDX_W'({g[PTEG_INDEX_BITS-1:0], 3'b000});
  endfunction

  task automatic resolve_pte_op(input logic [1:0] op, input logic [31:0] va,
                                input logic [23:0] vsid, input logic [31:0] word,
                                output pte_outcome_t res);
    logic [HASH_W-1:0]     hash;
    logic [SLOT_IDX_W-1:0] pri_base;
    logic [SLOT_IDX_W-1:0] sec_base;
    logic [SLOT_IDX_W-1:0] base;
    logic [SLOT_IDX_W-1:0] idx;
    logic [SLOT_IDX_W-1:0] slot;
    logic [5:0]            api;
    logic [31:0]           tag;
    logic                  hit;
    logic                  in_sec;
    logic                  usable;
    int                    pass;
    int                    i;
    res    = '0;
    hit    = 1'b0;
    in_sec = 1'b0;
    slot   = '0;
    hash     = vsid[HASH_W-1:0] ^ {3'b000, va[27:12]};
    pri_base = group_base(hash);
    sec_base = group_base(~hash);
    api      = va[27:22];
    case (op)
      MODE_LOOKUP, MODE_INVAL: begin
        // primary group first; secondary entries carry H set
        for (pass = 0; pass < 2; pass++) begin
          base = pass[0] ? sec_base : pri_base;
          tag  = {1'b1, vsid, pass[0], api};
          for (i = 0; i < GROUP_SLOTS; i++) begin
            idx = base + SLOT_IDX_W'(i);
            if (!hit && pte_shadow[idx][63:32] == tag) begin
              hit    = 1'b1;
              slot   = idx;
              in_sec = pass[0];
            end
          end
        end
        if (hit) begin
          res.found = 1'b1;
          res.slot  = slot;
          res.sec   = in_sec;
          if (op == MODE_LOOKUP) begin
            res.entry = pte_shadow[slot][31:0];
          end else begin
            pte_shadow[slot] = '0;
            res.disp         = 1'b1;
          end
        end
      end
      MODE_INSERT: begin
        // invalid primary, invalid secondary, R/C clear primary, R/C clear secondary
        for (pass = 0; pass < 4; pass++) begin
          base = pass[0] ? sec_base : pri_base;
          for (i = 0; i < GROUP_SLOTS; i++) begin
            idx = base + SLOT_IDX_W'(i);
            if (pass < 2) usable = !pte_shadow[idx][V_POS];
            else usable = !pte_shadow[idx][R_POS] && !pte_shadow[idx][C_POS];
            if (!hit && usable) begin
              hit    = 1'b1;
              slot   = idx;
              in_sec = pass[0];
            end
          end
        end
        if (!hit) begin
          slot   = sec_base;
          in_sec = 1'b1;
        end
        res.disp         = pte_shadow[slot][V_POS];
        pte_shadow[slot] = {1'b1, vsid, in_sec, api, word};
        res.found        = 1'b1;
        res.slot         = slot;
        res.sec          = in_sec;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (row = 0; row < TABLE_DEPTH; row++) pte_shadow[row] = '0;
      mask_q = '0;
      pte_outcomes_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      hits_o       = 0;
      secondary_o  = 0;
      displaced_o  = 0;
    end else begin
      if (cfg_we_i) mask_q = cfg_wdata_i;

      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tdata[0];
        got.entry = m_axis_tdata[32:1];
        got.slot  = m_axis_tdata[46:33];
        got.sec   = m_axis_tdata[47];
        got.disp  = m_axis_tdata[48];
        if (pte_outcomes_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result transfer with nothing outstanding: %h",
                     $time, m_axis_tdata);
        end else begin
          want = pte_outcomes_q.pop_front();
          results_o++;
          if (want.found && got.found) hits_o++;
          if (want.sec) secondary_o++;
          if (want.disp) displaced_o++;
          if (got.found !== want.found || got.entry !== want.entry ||
              got.slot !== want.slot || got.sec !== want.sec || got.disp !== want.disp) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: mismatch exp found=%0d entry=%h slot=%0d sec=%0d disp=%0d,",
                        " got found=%0d entry=%h slot=%0d sec=%0d disp=%0d"},
                       $time, want.found, want.entry, want.slot, want.sec, want.disp,
                       got.found, got.entry, got.slot, got.sec, got.disp);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        resolve_pte_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[55:32],
                       s_axis_tdata[87:56], want);
        pte_outcomes_q.push_back(want);
      end

      pending_o = pte_outcomes_q.size();
    end
  end

endmodule

[tb/tb_hashed_page_table_engine_top.sv]
`timescale 1ns / 1ps

module tb_hashed_page_table_engine_top
  import hpte_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 10000;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 100;
  localparam int KEY_POOL    = 48;

  typedef struct packed {
    logic [31:0] va;
    logic [23:0] vsid;
  } page_key_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [MASK_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [87:0]       s_axis_tdata  = '0;   // virt_addr, segment_vsid, entry_word
  logic [1:0]        s_axis_tuser  = '0;   // mode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [55:0]       m_axis_tdata;         // found, entry_out, slot_index,
                                           // used_secondary, displaced_valid

  int fails;
  int pending;
  int results;
  int hits;
  int secondary;
  int displaced;

  logic       quiet        = 1'b0;
  int         stall_left   = 0;
  int         idle_cycles  = 0;
  int         mask_settings = 0;
  int         directed_ops = 0;
  logic [9:0] hot_lows [4];
  page_key_t  live_keys [$];

  hashed_page_table_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hpte_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .results_o     (results),
    .hits_o        (hits),
    .secondary_o   (secondary),
    .displaced_o   (displaced)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: stall in bursts unless a quiet stretch is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left    = $urandom_range(1, 13) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [31:0] va,
                         input logic [23:0] vsid, input logic [31:0] word);
    int gap;
    gap = 0;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {word, vsid, va};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // drain, let the pipeline settle, then write the mask
  task automatic set_mask(input logic [MASK_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mask_settings++;
  endtask

  // most keys land on a few crowded group pairs so groups fill up
  task automatic make_key(output logic [31:0] va, output logic [23:0] vsid);
    logic [15:0] page;
    vsid = 24'($urandom);
    if ($urandom_range(0, 9) < 7)
      page = {6'($urandom), hot_lows[$urandom_range(0, 3)] ^ vsid[9:0]};
    else
      page = 16'($urandom);
    va = {4'($urandom), page, 12'($urandom)};
  endtask

  task automatic random_op();
    int          pick;
    int          k;
    logic [1:0]  op;
    logic [31:0] va;
    logic [31:0] word;
    logic [23:0] vsid;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = MODE_INSERT;
    else if (pick < 75) op = MODE_LOOKUP;
    else if (pick < 95) op = MODE_INVAL;
    else op = MODE_UNUSED;
    make_key(va, vsid);
    word = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      word[R_POS] = 1'b0;
      word[C_POS] = 1'b0;
    end
    if ((op == MODE_LOOKUP || op == MODE_INVAL) && live_keys.size() > 0 &&
        $urandom_range(0, 3) != 0) begin
      k    = $urandom_range(0, live_keys.size() - 1);
      vsid = live_keys[k].vsid;
      va   = {4'($urandom), live_keys[k].va[27:12], 12'($urandom)};
      if (op == MODE_INVAL) live_keys.delete(k);
    end
    if (op == MODE_INSERT) begin
      live_keys.push_back('{va: va, vsid: vsid});
      if (live_keys.size() > KEY_POOL) void'(live_keys.pop_front());
    end
    send_op(op, va, vsid, word);
  endtask

  task automatic directed_op(input logic [1:0] op, input logic [31:0] va,
                             input logic [23:0] vsid, input logic [31:0] word);
    send_op(op, va, vsid, word);
    directed_ops++;
  endtask

  initial begin
    logic [MASK_W-1:0] phase_masks [PHASES];
    int                phase;
    int                n;
    int                k;
    hot_lows    = '{10'h000, 10'h3ff, 10'($urandom), 10'($urandom)};
    phase_masks = '{9'h1ff, 9'($urandom), 9'h001, 9'h000};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_mask(9'h000);
    // empty table misses and the unused mode
    directed_op(MODE_LOOKUP, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    directed_op(MODE_INVAL, 32'hffff_ffff, 24'hff_ffff, 32'hffff_ffff);
    directed_op(MODE_UNUSED, 32'hffff_ffff, 24'hff_ffff, 32'hffff_ffff);
    // field extremes: insert, find, clear, miss again
    directed_op(MODE_INSERT, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    directed_op(MODE_INSERT, 32'hffff_ffff, 24'hff_ffff, 32'hffff_ffff);
    directed_op(MODE_LOOKUP, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    directed_op(MODE_LOOKUP, 32'hffff_ffff, 24'hff_ffff, 32'h0000_0000);
    directed_op(MODE_INVAL, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    directed_op(MODE_LOOKUP, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
    // ten tags on one hash: the primary group fills, the rest spill to secondary
    for (k = 0; k < 10; k++)
      directed_op(MODE_INSERT, 32'h0123_4567, {5'(k), 19'h0}, $urandom);
    directed_op(MODE_LOOKUP, 32'h0123_4567, {5'd9, 19'h0}, 32'h0);
    directed_op(MODE_INVAL, 32'h0123_4567, {5'd9, 19'h0}, 32'h0);
    directed_op(MODE_LOOKUP, 32'h0123_4567, {5'd3, 19'h0}, 32'h0);

    for (phase = 0; phase < PHASES; phase++) begin
      set_mask(phase_masks[phase]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == PHASES - 1) quiet = 1'b1;
        else if (n % 20 == 0) quiet = ($urandom_range(0, 2) == 0);
        random_op();
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Covered %0d operations (%0d directed) over %0d hash-mask settings.",
             results, directed_ops, mask_settings);
    $display("Matched or written %0d times, %0d slots in secondary groups,",
             hits, secondary);
    $display("%0d valid entries displaced.", displaced);
    if (fails == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
